@@ sv/sorted_list_insert_find_macros.svh @@
// ---------------------------------------------------------------------------
// Sorted list insert/find assertion macros
// Shorthands for concurrent checks on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_FIND_MACROS_SVH
`define SORTED_LIST_INSERT_FIND_MACROS_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define SLIF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slif: same-cycle check failed");
// Check cons in the cycle after ante.
`define SLIF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slif: next-cycle check failed");
`else
`define SLIF_ASSERT_IMPL(label, ante, cons)
`define SLIF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ sv/slif_pkg.sv @@
// ---------------------------------------------------------------------------
// Sorted list insert/find package
// Shared widths, codes and the control word sent to the storage cells.
// ---------------------------------------------------------------------------
package slif_pkg;

  localparam int VALUE_W = 32;
  localparam int FIELD_W = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic load;    // insert: keep, take key, or take left neighbor
    logic rotate;  // find: take right neighbor, last cell takes cell 0
  } cell_ctrl_t;

endpackage

@@ sv/slif_cell.sv @@
// ---------------------------------------------------------------------------
// Sorted list storage cell
// Holds one value; on insert compares with the key and shifts right,
// on scan hands its value to the left neighbor.
// ---------------------------------------------------------------------------
module slif_cell (
  input  logic                                       clk,
  input  slif_pkg::cell_ctrl_t                       ctrl,
  input  logic signed [slif_pkg::VALUE_W-1:0]        key,
  input  logic                                       occupied,
  input  logic signed [slif_pkg::VALUE_W-1:0]        prev_value,
  input  logic                                       prev_lt,
  input  logic signed [slif_pkg::VALUE_W-1:0]        next_value,
  output logic signed [slif_pkg::VALUE_W-1:0]        value,
  output logic                                       lt
);
  import slif_pkg::*;

  // Stored values are ascending, so lt forms a prefix along the row.
  assign lt = occupied && (value < key);

  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      value <= next_value;
    end else if (ctrl.load && !lt) begin
      // first cell not below the key takes it, the rest shift right
      value <= prev_lt ? key : prev_value;
    end
  end

endmodule

@@ sv/sorted_list_insert_find.sv @@
// ---------------------------------------------------------------------------
// Sorted list insert/find
// Ascending store of signed 32-bit values built as a row of cells.
// ---------------------------------------------------------------------------
// An insert is taken while idle and its result word appears on the next
// cycle; the block stays ready, so inserts may follow back to back. A find
// rotates the row once through cell 0, one entry per cycle, while the head
// compares it with the key, and busy stays high while the row rotates.
// done is high for a single cycle; position and status hold their values
// until the next result. position and count report the low five bits of
// the internal values. No clearing pass runs after reset.
`include "sorted_list_insert_find_macros.svh"

module sorted_list_insert_find #(
  parameter int CAPACITY = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  opcode,
  input  logic signed [slif_pkg::VALUE_W-1:0]   value,
  output logic                                  done,
  output logic [slif_pkg::FIELD_W-1:0]          position,
  output logic                                  status,
  output logic [slif_pkg::FIELD_W-1:0]          count
);
  import slif_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = $clog2(CAPACITY);
  localparam logic [KW-1:0] LAST_STEP = KW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  state_t                      state, state_next;
  logic [KW-1:0]               step, step_next;
  logic                        searching, searching_next;
  logic [CW-1:0]               pos_acc, pos_acc_next;
  logic signed [VALUE_W-1:0]   key_q, key_next;
  logic [CW-1:0]               stored_count, stored_count_next;
  logic                        done_next;
  logic [CW-1:0]               res_pos, res_pos_next;
  logic                        res_status, res_status_next;

  cell_ctrl_t                  ctrl;
  logic signed [VALUE_W-1:0]   cell_value [CAPACITY];
  logic                        cell_lt    [CAPACITY];
  logic                        cell_occ   [CAPACITY];

  logic                        full;
  logic                        in_range;
  logic                        head_eq;
  logic                        head_gt;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_occ[i] = (CW'(i) < stored_count);
    if (i == 0) begin : g_head
      slif_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .key        (value),
        .occupied   (cell_occ[i]),
        .prev_value (value),
        .prev_lt    (1'b0),
        .next_value (cell_value[(i + 1) % CAPACITY]),
        .value      (cell_value[i]),
        .lt         (cell_lt[i])
      );
    end else begin : g_body
      slif_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .key        (value),
        .occupied   (cell_occ[i]),
        .prev_value (cell_value[i - 1]),
        .prev_lt    (cell_lt[i - 1]),
        .next_value (cell_value[(i + 1) % CAPACITY]),
        .value      (cell_value[i]),
        .lt         (cell_lt[i])
      );
    end
  end

  assign full     = (stored_count == FULL_COUNT);
  assign in_range = (CW'(step) < stored_count);
  assign head_eq  = (cell_value[0] == key_q);
  assign head_gt  = (cell_value[0] > key_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stored_count <= '0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      stored_count <= stored_count_next;
      done         <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    step       <= step_next;
    searching  <= searching_next;
    pos_acc    <= pos_acc_next;
    key_q      <= key_next;
    res_pos    <= res_pos_next;
    res_status <= res_status_next;
  end

  always_comb begin
    state_next        = state;
    step_next         = step;
    searching_next    = searching;
    pos_acc_next      = pos_acc;
    key_next          = key_q;
    stored_count_next = stored_count;
    done_next         = 1'b0;
    res_pos_next      = res_pos;
    res_status_next   = res_status;
    ctrl              = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (opcode == OP_INSERT) begin
            ctrl.load       = !full;
            done_next       = 1'b1;
            res_pos_next    = '0;
            res_status_next = full ? STATUS_FULL : STATUS_OK;
            if (!full) begin
              stored_count_next = stored_count + CW'(1);
            end
          end else begin
            key_next       = value;
            step_next      = '0;
            searching_next = 1'b1;
            pos_acc_next   = '0;
            state_next     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ctrl.rotate = 1'b1;
        if (searching) begin
          if (in_range && head_eq) begin
            pos_acc_next   = CW'(step) + CW'(1);
            searching_next = 1'b0;
          end else if (!in_range || head_gt) begin
            searching_next = 1'b0;
          end
        end
        if (step == LAST_STEP) begin
          // row is back in place after a full turn
          state_next      = S_IDLE;
          done_next       = 1'b1;
          res_pos_next    = pos_acc_next;
          res_status_next = STATUS_OK;
        end else begin
          step_next = step + KW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy     = (state == S_SCAN);
  assign position = FIELD_W'(res_pos);
  assign status   = res_status;
  assign count    = FIELD_W'(stored_count);

  `SLIF_ASSERT_IMPL(a_count_cap, 1'b1, stored_count <= FULL_COUNT)
  `SLIF_ASSERT_IMPL(a_pos_bound, done, res_pos <= stored_count)
  `SLIF_ASSERT_IMPL(a_found_ok, done && (res_pos != '0), res_status == STATUS_OK)
  `SLIF_ASSERT_NEXT(a_no_early_done, busy && (step != LAST_STEP), !done)
  `SLIF_ASSERT_NEXT(a_drop_full, start && !busy && (opcode == OP_INSERT) && full, done && (res_status == STATUS_FULL) && $stable(stored_count))

endmodule
